>>> design/small_language_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the small language tokenizer
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMALL_LANGUAGE_TOKENIZER_ASSERT_SVH
`define SMALL_LANGUAGE_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define SLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLT_ASSERT(label, prop, msg)
`define SLT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> design/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared widths, codes, token record and helpers of the tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Internal counter widths (counters saturate at their all-ones value)
    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // Field widths of a token transaction
    localparam int OFS_W  = 24;
    localparam int LEN_W  = 16;
    localparam int LINE_W = 20;
    localparam int COL_W  = 16;
    localparam int KIND_W = 4;

    // Token queue; depth must be a power of two and at least two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_DASH,
        M_SLASH,
        M_COMMENT
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        K_IDENT,
        K_INT,
        K_FN,
        K_RETURN,
        K_LPAREN,
        K_RPAREN,
        K_LBRACE,
        K_RBRACE,
        K_ARROW,
        K_SEMI,
        K_UNKNOWN,
        K_EOF
    } kind_t;

    typedef enum logic [1:0] {
        KW_NONE,
        KW_FN,
        KW_RETURN
    } kw_t;

    typedef struct packed {
        kind_t             kind;
        logic [OFS_W-1:0]  start_offset;
        logic [LEN_W-1:0]  token_length;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column_number;
        logic              last_of_run;
    } token_t;

    // Tokens produced by one input transaction (count is 0, 1 or 2)
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // Clamp internal counters to the width of their output field
    function automatic logic [OFS_W-1:0] clamp_offset(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OFS_W-1:0] wide;
        wide = (OFFSET_BITS+OFS_W)'(v);
        if (wide > (OFFSET_BITS+OFS_W)'({OFS_W{1'b1}}))
            clamp_offset = '1;
        else
            clamp_offset = wide[OFS_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] clamp_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+LINE_W-1:0] wide;
        wide = (LINE_BITS+LINE_W)'(v);
        if (wide > (LINE_BITS+LINE_W)'({LINE_W{1'b1}}))
            clamp_line = '1;
        else
            clamp_line = wide[LINE_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] clamp_column(input logic [COLUMN_BITS-1:0] v);
        logic [COLUMN_BITS+COL_W-1:0] wide;
        wide = (COLUMN_BITS+COL_W)'(v);
        if (wide > (COLUMN_BITS+COL_W)'({COL_W{1'b1}}))
            clamp_column = '1;
        else
            clamp_column = wide[COL_W-1:0];
    endfunction

endpackage

>>> design/slt_if.sv
// ----------------------------------------------------------------------------
// Tokenizer channel interfaces
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------

// Text byte channel
interface slt_in_if import slt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] text_byte;

    modport source (output valid, output func, output text_byte, input ready);
    modport sink   (input valid, input func, input text_byte, output ready);
endinterface

// Token channel
interface slt_out_if import slt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [OFS_W-1:0]  start_offset;
    logic [LEN_W-1:0]  token_length;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column_number;
    logic              last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_number, output column_number,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_number, input column_number,
                    input last_of_run, output ready);
endinterface

>>> design/slt_lexer.sv
// ----------------------------------------------------------------------------
// slt_lexer
// Scan state and per-byte classification; emits up to two tokens per byte.
// ----------------------------------------------------------------------------
`include "small_language_tokenizer_assert.svh"

module slt_lexer import slt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       func,
    input  logic [7:0] text_byte,
    output push_t      push
);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;

    // Keyword spellings
    localparam logic [7:0] WORD_FN  [2] = '{8'h66, 8'h6E};
    localparam logic [7:0] WORD_RET [6] = '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E};

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [OFFSET_BITS-1:0] ostart_reg, ostart_next;
    logic [COLUMN_BITS-1:0] ocol_reg, ocol_next;
    logic [LEN_W-1:0]       olen_reg, olen_next;
    kw_t                    kw_reg, kw_next;

    logic   is_alpha, is_digit, is_blank, is_nl;
    logic   pend_has, close_emit, byte_emit, used, is_arrow;
    kind_t  pend_kind, byte_kind;
    token_t close_tok, byte_tok, eof_tok;
    logic   fn_ok, ret_ok;

    // Byte classes
    assign is_alpha = text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
    assign is_digit = text_byte inside {[8'h30:8'h39]};
    assign is_blank = text_byte inside {CH_SPACE, CH_CR, CH_TAB, CH_LF};
    assign is_nl    = (text_byte == CH_LF);

    // Keyword candidate still matching after this byte
    assign fn_ok  = (olen_reg < LEN_W'(2)) && (WORD_FN[olen_reg[0]] == text_byte);
    assign ret_ok = (olen_reg < LEN_W'(6)) && (WORD_RET[olen_reg[2:0]] == text_byte);

    // Pending token kind
    always_comb
    begin
        case (mode_reg)
            M_IDENT:
            begin
                if (kw_reg == KW_FN && olen_reg == LEN_W'(2))
                    pend_kind = K_FN;
                else if (kw_reg == KW_RETURN && olen_reg == LEN_W'(6))
                    pend_kind = K_RETURN;
                else
                    pend_kind = K_IDENT;
            end
            M_INT:   pend_kind = K_INT;
            default: pend_kind = K_UNKNOWN;
        endcase
    end

    assign pend_has = (mode_reg inside {M_IDENT, M_INT, M_DASH, M_SLASH});
    assign is_arrow = !func && (mode_reg == M_DASH) && (text_byte == CH_GT);

    // Single-byte token kind
    always_comb
    begin
        case (text_byte)
            CH_LPAREN: byte_kind = K_LPAREN;
            CH_RPAREN: byte_kind = K_RPAREN;
            CH_LBRACE: byte_kind = K_LBRACE;
            CH_RBRACE: byte_kind = K_RBRACE;
            CH_SEMI:   byte_kind = K_SEMI;
            default:   byte_kind = K_UNKNOWN;
        endcase
    end

    // Candidate token records
    always_comb
    begin
        close_tok.kind          = is_arrow ? K_ARROW : pend_kind;
        close_tok.start_offset  = clamp_offset(ostart_reg);
        if (mode_reg == M_IDENT || mode_reg == M_INT)
            close_tok.token_length = olen_reg;
        else
            close_tok.token_length = is_arrow ? LEN_W'(2) : LEN_W'(1);
        close_tok.line_number   = clamp_line(line_reg);
        close_tok.column_number = clamp_column(ocol_reg);
        close_tok.last_of_run   = 1'b0;

        byte_tok.kind           = byte_kind;
        byte_tok.start_offset   = clamp_offset(offset_reg);
        byte_tok.token_length   = LEN_W'(1);
        byte_tok.line_number    = clamp_line(line_reg);
        byte_tok.column_number  = clamp_column(col_reg);
        byte_tok.last_of_run    = 1'b0;

        eof_tok.kind            = K_EOF;
        eof_tok.start_offset    = clamp_offset(offset_reg);
        eof_tok.token_length    = '0;
        eof_tok.line_number     = clamp_line(line_reg);
        eof_tok.column_number   = clamp_column(col_reg);
        eof_tok.last_of_run     = 1'b0;
    end

    // Next scan state and emitted tokens
    always_comb
    begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        ostart_next = ostart_reg;
        ocol_next   = ocol_reg;
        olen_next   = olen_reg;
        kw_next     = kw_reg;
        close_emit  = 1'b0;
        byte_emit   = 1'b0;
        used        = 1'b0;
        push        = '0;
        push.tok0   = byte_tok;
        push.tok1   = byte_tok;

        if (item_valid && func)
        begin
            // End of text: flush, eof, back to reset values
            push.tok0   = pend_has ? close_tok : eof_tok;
            push.tok1   = eof_tok;
            push.count  = pend_has ? 2'd2 : 2'd1;
            mode_next   = M_IDLE;
            offset_next = '0;
            line_next   = LINE_BITS'(1);
            col_next    = COLUMN_BITS'(1);
            ostart_next = '0;
            ocol_next   = COLUMN_BITS'(1);
            olen_next   = '0;
            kw_next     = KW_NONE;
        end
        else if (item_valid)
        begin
            // Continue or close the open token
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha || is_digit)
                    begin
                        used = 1'b1;
                        if (olen_reg != '1)
                            olen_next = olen_reg + LEN_W'(1);
                        if ((kw_reg == KW_FN && !fn_ok) || (kw_reg == KW_RETURN && !ret_ok))
                            kw_next = KW_NONE;
                    end
                    else
                        close_emit = 1'b1;
                end
                M_INT:
                begin
                    if (is_digit)
                    begin
                        used = 1'b1;
                        if (olen_reg != '1)
                            olen_next = olen_reg + LEN_W'(1);
                    end
                    else
                        close_emit = 1'b1;
                end
                M_DASH:
                begin
                    close_emit = 1'b1;
                    used       = is_arrow;
                    mode_next  = M_IDLE;
                end
                M_SLASH:
                begin
                    if (text_byte == CH_SLASH)
                    begin
                        used      = 1'b1;
                        mode_next = M_COMMENT;
                    end
                    else
                        close_emit = 1'b1;
                end
                M_COMMENT:
                begin
                    used = 1'b1;
                    if (is_nl)
                        mode_next = M_IDLE;
                end
                default: ;
            endcase

            // Byte not absorbed: start a token or emit a one-byte token
            if (!used)
            begin
                mode_next = M_IDLE;
                if (!is_blank)
                begin
                    if (is_alpha || is_digit || text_byte == CH_DASH ||
                        text_byte == CH_SLASH)
                    begin
                        ostart_next = offset_reg;
                        ocol_next   = col_reg;
                        olen_next   = LEN_W'(1);
                    end
                    if (is_alpha)
                    begin
                        mode_next = M_IDENT;
                        if (text_byte == CH_F)
                            kw_next = KW_FN;
                        else if (text_byte == CH_R)
                            kw_next = KW_RETURN;
                        else
                            kw_next = KW_NONE;
                    end
                    else if (is_digit)
                        mode_next = M_INT;
                    else if (text_byte == CH_DASH)
                        mode_next = M_DASH;
                    else if (text_byte == CH_SLASH)
                        mode_next = M_SLASH;
                    else
                        byte_emit = 1'b1;
                end
            end

            // Position counters
            if (offset_reg != '1)
                offset_next = offset_reg + OFFSET_BITS'(1);
            if (is_nl)
            begin
                col_next = COLUMN_BITS'(1);
                if (line_reg != '1)
                    line_next = line_reg + LINE_BITS'(1);
            end
            else if (col_reg != '1)
                col_next = col_reg + COLUMN_BITS'(1);

            if (close_emit)
            begin
                push.tok0  = close_tok;
                push.count = byte_emit ? 2'd2 : 2'd1;
            end
            else
                push.count = byte_emit ? 2'd1 : 2'd0;
        end

        // Mark the final token of this transaction
        push.tok0.last_of_run = (push.count == 2'd1);
        push.tok1.last_of_run = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            offset_reg <= '0;
            line_reg   <= LINE_BITS'(1);
            col_reg    <= COLUMN_BITS'(1);
            ostart_reg <= '0;
            ocol_reg   <= COLUMN_BITS'(1);
            olen_reg   <= '0;
            kw_reg     <= KW_NONE;
        end
        else
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            ostart_reg <= ostart_next;
            ocol_reg   <= ocol_next;
            olen_reg   <= olen_next;
            kw_reg     <= kw_next;
        end
    end

    // Checks
    `SLT_ASSERT_NEXT(a_eof_restarts, item_valid && func, mode_reg == M_IDLE && offset_reg == '0 && line_reg == LINE_BITS'(1), "end transaction did not restart the scan")
    `SLT_ASSERT(a_comment_silent, (item_valid && !func && mode_reg == M_COMMENT) |-> push.count == 2'd0, "token emitted inside a comment")
    `SLT_ASSERT(a_open_len_nonzero, (mode_reg == M_IDENT || mode_reg == M_INT) |-> olen_reg != '0, "open token has zero length")

endmodule

>>> design/slt_token_fifo.sv
// ----------------------------------------------------------------------------
// slt_token_fifo
// Small token queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
`include "small_language_tokenizer_assert.svh"

module slt_token_fifo import slt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      room,
    slt_out_if.source token_out
);

    token_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    token_t                head;

    assign pop        = token_out.valid && token_out.ready;
    assign wr_ptr_inc = wr_ptr_reg + FIFO_PTR_W'(1);

    // Enough space for the worst case of one transaction
    assign room = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.tok0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_inc] <= push.tok1;
    end

    // Head of queue drives the output channel
    assign head                    = mem_reg[rd_ptr_reg];
    assign token_out.valid         = (count_reg != '0);
    assign token_out.token_kind    = head.kind;
    assign token_out.start_offset  = head.start_offset;
    assign token_out.token_length  = head.token_length;
    assign token_out.line_number   = head.line_number;
    assign token_out.column_number = head.column_number;
    assign token_out.last_of_run   = head.last_of_run;

    // Checks
    `SLT_ASSERT(a_no_overflow, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "token queue overflow")
    `SLT_ASSERT(a_push_fits, push.count != 2'd3, "invalid token count pushed")
    `SLT_ASSERT_NEXT(a_pop_drains, pop && push.count == 2'd0, count_reg == $past(count_reg) - 1'b1, "fill count did not drop on read")

endmodule

>>> design/small_language_tokenizer.sv
// ----------------------------------------------------------------------------
// small_language_tokenizer
// Streaming lexer: text bytes in, tokens with position information out.
// ----------------------------------------------------------------------------
// Usage:
//   text_in carries one transaction per source byte (func = 0) and one end
//   transaction (func = 1) after the last byte. token_out carries one token
//   per transaction; last_of_run marks the final token caused by an input.
//   A byte may cause zero, one or two tokens; the end transaction causes the
//   pending token, if any, and then an eof token, and restarts the scan.
// Throughput: one input transaction per cycle while the receiver keeps up;
//   the token queue and the single token read per cycle set the rate when
//   bytes produce two tokens.
// Path: a token caused by an accepted byte goes through the input register,
//   then the lexer logic into the token queue, which drives token_out.
// Reset: the scan returns to offset 0, line 1, column 1 with nothing pending,
//   and the token queue empties.
// Stall: while token_out is held off, the four-entry queue fills; text_in
//   ready drops once fewer than two free entries remain. Nothing is dropped.
// ----------------------------------------------------------------------------
module small_language_tokenizer import slt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    slt_in_if.sink    text_in,
    slt_out_if.source token_out
);

    logic       a_valid_reg, a_valid_next;
    logic       a_func_reg;
    logic [7:0] a_byte_reg;
    logic       accept, a_fire, room;
    push_t      push;

    // Input register handshake
    assign a_fire        = a_valid_reg && room;
    assign text_in.ready = !a_valid_reg || a_fire;
    assign accept        = text_in.valid && text_in.ready;

    always_comb
    begin
        if (accept)
            a_valid_next = 1'b1;
        else if (a_fire)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_func_reg <= text_in.func;
            a_byte_reg <= text_in.text_byte;
        end
    end

    slt_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (a_fire),
        .func       (a_func_reg),
        .text_byte  (a_byte_reg),
        .push       (push)
    );

    slt_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .token_out (token_out)
    );

endmodule

>>> dv/small_language_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_language_tokenizer_tb
// Drives source text and end markers into the tokenizer and checks every
// token against an in-bench lexer model. Covers fixed snippets, random
// programs with noise bytes and output backpressure.
// ----------------------------------------------------------------------------
module small_language_tokenizer_tb;
    import slt_pkg::*;

    // Input transaction kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Character classes and punctuation
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    localparam logic [15:0] FN_WORD  = "fn";
    localparam logic [47:0] RET_WORD = "return";

    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 120;
    localparam int REPORT_LIMIT = 40;

    logic clk = 1'b0;
    logic rst_n;

    slt_in_if  text_in ();
    slt_out_if token_out ();

    small_language_tokenizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .token_out (token_out)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Lexer model state
    mode_t             lex_mode;
    kw_t               kw_guess;
    logic [OFFSET_BITS-1:0] lex_offset;
    logic [LINE_BITS-1:0]   lex_line;
    logic [COLUMN_BITS-1:0] lex_column;
    logic [OFFSET_BITS-1:0] tok_start_ofs;
    logic [COLUMN_BITS-1:0] tok_start_col;
    logic [LEN_W-1:0]       tok_len;

    token_t tokens_due[$];
    token_t step_buf[2];
    int     step_count;

    // Bench control and statistics
    bit          src_gaps;
    bit          sink_gaps;
    int          hold_req;
    int          items_sent;
    int          ends_sent;
    int          tokens_checked;
    int          error_count;
    int          quiet_cycles;
    logic [11:0] kinds_seen;

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SP || b == CH_CR || b == CH_TAB || b == CH_NL;
    endfunction

    function automatic void reset_lexer();
        lex_mode      = M_IDLE;
        kw_guess      = KW_NONE;
        lex_offset    = '0;
        lex_line      = LINE_BITS'(1);
        lex_column    = COLUMN_BITS'(1);
        tok_start_ofs = '0;
        tok_start_col = COLUMN_BITS'(1);
        tok_len       = '0;
    endfunction

    function automatic void note_token(kind_t k, logic [OFS_W-1:0] s, logic [LEN_W-1:0] l,
                                       logic [COL_W-1:0] c);
        token_t t;
        t.kind          = k;
        t.start_offset  = s;
        t.token_length  = l;
        t.line_number   = lex_line;
        t.column_number = c;
        t.last_of_run   = 1'b0;
        step_buf[step_count] = t;
        step_count++;
    endfunction

    // Close whatever token is open
    function automatic void close_open_token();
        kind_t k;
        case (lex_mode)
            M_IDENT:
            begin
                k = K_IDENT;
                if (kw_guess == KW_FN && tok_len == 2)
                    k = K_FN;
                else if (kw_guess == KW_RETURN && tok_len == 6)
                    k = K_RETURN;
                note_token(k, tok_start_ofs, tok_len, tok_start_col);
            end
            M_INT:
                note_token(K_INT, tok_start_ofs, tok_len, tok_start_col);
            M_DASH, M_SLASH:
                note_token(K_UNKNOWN, tok_start_ofs, LEN_W'(1), tok_start_col);
            default: ;
        endcase
        lex_mode = M_IDLE;
    endfunction

    function automatic void open_token(mode_t m);
        lex_mode      = m;
        tok_start_ofs = lex_offset;
        tok_start_col = lex_column;
        tok_len       = LEN_W'(1);
    endfunction

    // Drop the keyword candidate once the identifier departs from it
    function automatic void track_keyword(logic [7:0] b);
        int idx;
        idx = int'(tok_len);
        if (kw_guess == KW_FN)
        begin
            if (idx >= 2)
                kw_guess = KW_NONE;
            else if (b != FN_WORD[8*(1-idx) +: 8])
                kw_guess = KW_NONE;
        end
        else if (kw_guess == KW_RETURN)
        begin
            if (idx >= 6)
                kw_guess = KW_NONE;
            else if (b != RET_WORD[8*(5-idx) +: 8])
                kw_guess = KW_NONE;
        end
    endfunction

    // Expected tokens for one accepted input transaction
    function automatic void lex_step(logic f, logic [7:0] b);
        bit    used;
        kind_t k;
        step_count = 0;
        used       = 1'b0;
        if (f == FUNC_END)
        begin
            if (lex_mode == M_COMMENT)
                lex_mode = M_IDLE;
            close_open_token();
            note_token(K_EOF, lex_offset, '0, lex_column);
            reset_lexer();
        end
        else
        begin
            case (lex_mode)
                M_IDENT:
                    if (is_alpha(b) || is_digit(b))
                    begin
                        track_keyword(b);
                        if (tok_len != '1)
                            tok_len++;
                        used = 1'b1;
                    end
                    else
                        close_open_token();
                M_INT:
                    if (is_digit(b))
                    begin
                        if (tok_len != '1)
                            tok_len++;
                        used = 1'b1;
                    end
                    else
                        close_open_token();
                M_DASH:
                    if (b == CH_GT)
                    begin
                        note_token(K_ARROW, tok_start_ofs, LEN_W'(2), tok_start_col);
                        lex_mode = M_IDLE;
                        used     = 1'b1;
                    end
                    else
                        close_open_token();
                M_SLASH:
                    if (b == CH_SLASH)
                    begin
                        lex_mode = M_COMMENT;
                        used     = 1'b1;
                    end
                    else
                        close_open_token();
                M_COMMENT:
                begin
                    if (b == CH_NL)
                        lex_mode = M_IDLE;
                    used = 1'b1;
                end
                default:
                    lex_mode = M_IDLE;
            endcase

            // Byte not consumed by an open token starts something new
            if (!used && !is_blank(b))
            begin
                if (is_alpha(b))
                begin
                    open_token(M_IDENT);
                    kw_guess = (b == "f") ? KW_FN : (b == "r") ? KW_RETURN : KW_NONE;
                end
                else if (is_digit(b))
                    open_token(M_INT);
                else if (b == CH_DASH)
                    open_token(M_DASH);
                else if (b == CH_SLASH)
                    open_token(M_SLASH);
                else
                begin
                    case (b)
                        CH_LPAREN: k = K_LPAREN;
                        CH_RPAREN: k = K_RPAREN;
                        CH_LBRACE: k = K_LBRACE;
                        CH_RBRACE: k = K_RBRACE;
                        CH_SEMI:   k = K_SEMI;
                        default:   k = K_UNKNOWN;
                    endcase
                    note_token(k, lex_offset, LEN_W'(1), lex_column);
                end
            end

            // Position counters saturate at their width
            if (lex_offset != '1)
                lex_offset++;
            if (b == CH_NL)
            begin
                if (lex_line != '1)
                    lex_line++;
                lex_column = COLUMN_BITS'(1);
            end
            else if (lex_column != '1)
                lex_column++;
        end

        if (step_count > 0)
            step_buf[step_count-1].last_of_run = 1'b1;
        for (int i = 0; i < step_count; i++)
            tokens_due.insert(tokens_due.size(), step_buf[i]);
    endfunction

    // Random character pickers
    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_alnum();
        if ($urandom_range(0, 5) == 0)
            return 8'(CH_ZERO + $urandom_range(0, 9));
        return pick_alpha();
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 4))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_NL;
        endcase
    endfunction

    // One input transaction; starts and ends at a falling edge
    task automatic send_item(input logic f, input logic [7:0] b);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            text_in.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        text_in.valid     <= 1'b1;
        text_in.func      <= f;
        text_in.text_byte <= b;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        lex_step(f, b);
        items_sent++;
        if (f == FUNC_END)
            ends_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(FUNC_BYTE, s[i]);
    endtask

    // Stop offering and wait for every outstanding token
    task automatic drain_tokens();
        text_in.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // A random program: mostly well-formed tokens, some noise, then the end marker
    task automatic send_program();
        int n_tok;
        int len;
        n_tok = $urandom_range(1, 12);
        for (int t = 0; t < n_tok; t++)
        begin
            case ($urandom_range(0, 13))
                0: send_text("fn");
                1: send_text("return");
                2:
                begin
                    send_item(FUNC_BYTE, pick_alpha());
                    len = $urandom_range(0, 7);
                    repeat (len) send_item(FUNC_BYTE, pick_alnum());
                end
                3:
                begin
                    len = $urandom_range(1, 5);
                    repeat (len) send_item(FUNC_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));
                end
                4, 5: send_item(FUNC_BYTE, pick_punct());
                6: send_text("->");
                7:
                begin
                    // comment, sometimes left open to the end marker
                    send_text("//");
                    len = $urandom_range(0, 10);
                    repeat (len) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 3) != 0)
                        send_item(FUNC_BYTE, CH_NL);
                end
                8: send_item(FUNC_BYTE, pick_blank());
                9: send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
                10: send_item(FUNC_BYTE, $urandom_range(0, 1) ? CH_DASH : CH_SLASH);
                11:
                    case ($urandom_range(0, 6))
                        0: send_text("f");
                        1: send_text("fnn");
                        2: send_text("fn_");
                        3: send_text("r");
                        4: send_text("retur");
                        5: send_text("returnx");
                        default: send_text("Fn9");
                    endcase
                12: send_item(FUNC_BYTE, 8'($urandom_range(128, 255)));
                default: send_item(FUNC_BYTE, CH_NL);
            endcase
            if ($urandom_range(0, 1) == 0)
                send_item(FUNC_BYTE, pick_blank());
        end
        send_item(FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    // Fixed snippets: keywords, punctuation, lone dash/slash, odd blanks, end cases
    task automatic test_directed();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_item(FUNC_END, 8'hA5);
        send_text("fn(){};->return 7");
        send_item(FUNC_END, 8'h00);
        send_text("-/ //\n");
        send_item(FUNC_BYTE, CH_VT);
        send_item(FUNC_BYTE, CH_FF);
        send_item(FUNC_BYTE, CH_HIGH);
        send_item(FUNC_BYTE, 8'hFF);
        send_text("_9\tr");
        send_item(FUNC_END, 8'hFF);
        send_text("//");
        send_item(FUNC_END, 8'h5A);
        drain_tokens();
    endtask

    task automatic test_random_programs(input int n_items, input bit with_gaps);
        int first;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            // alternate stretches with and without idling
            src_gaps  = with_gaps && ($urandom_range(0, 3) != 0);
            sink_gaps = with_gaps && ($urandom_range(0, 3) != 0);
            send_program();
        end
        drain_tokens();
    endtask

    // Receiver holds off while two-token bytes keep coming, so the queue fills
    task automatic test_output_backpressure();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        hold_req  = LONG_HOLD;
        repeat (2) @(negedge clk);
        repeat (60)
        begin
            send_item(FUNC_BYTE, pick_alpha());
            send_item(FUNC_BYTE, pick_punct());
        end
        send_item(FUNC_END, 8'h00);
        drain_tokens();
    endtask

    // Receiver: random stall bursts plus an occasional long hold-off
    initial
    begin : token_sink
        int stall_left;
        stall_left      = 0;
        token_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0)
            begin
                token_out.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                token_out.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
                token_out.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Compare each token transaction with the oldest expected token
    always @(posedge clk)
    begin : token_checker
        token_t want;
        if (rst_n && token_out.valid && token_out.ready)
        begin
            if (tokens_due.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $error("token with no expectation: kind %0d offset %0d",
                           token_out.token_kind, token_out.start_offset);
            end
            else
            begin
                want = tokens_due.pop_front();
                check_field("token_kind", 32'(want.kind), 32'(token_out.token_kind));
                check_field("start_offset", 32'(want.start_offset),
                            32'(token_out.start_offset));
                check_field("token_length", 32'(want.token_length),
                            32'(token_out.token_length));
                check_field("line_number", 32'(want.line_number),
                            32'(token_out.line_number));
                check_field("column_number", 32'(want.column_number),
                            32'(token_out.column_number));
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(token_out.last_of_run));
                kinds_seen[want.kind] = 1'b1;
                tokens_checked++;
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (text_in.valid && text_in.ready) || (token_out.valid && token_out.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d idle cycles, %0d tokens outstanding",
                         quiet_cycles, tokens_due.size());
                $display("FAIL small_language_tokenizer");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        text_in.valid     = 1'b0;
        text_in.func      = FUNC_BYTE;
        text_in.text_byte = 8'h00;
        src_gaps          = 1'b0;
        sink_gaps         = 1'b0;
        hold_req          = 0;
        items_sent        = 0;
        ends_sent         = 0;
        tokens_checked    = 0;
        error_count       = 0;
        quiet_cycles      = 0;
        kinds_seen        = '0;
        reset_lexer();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_programs(940, 1'b1);
        test_output_backpressure();
        // closing stretch with no idling on either side
        test_random_programs(200, 1'b0);

        repeat (10) @(posedge clk);
        $display("%0d input transactions (%0d end markers), %0d tokens checked",
                 items_sent, ends_sent, tokens_checked);
        $display("%0d of 12 token kinds seen; long receiver hold-off and full drains run",
                 $countones(kinds_seen));
        if (error_count == 0)
            $display("PASS small_language_tokenizer");
        else
            $display("FAIL small_language_tokenizer");
        $finish;
    end

endmodule
